// ----- design/sm3_pkg.sv -----
// Shared types, constants and bit functions for the SM3 hash engine.
// Depends on nothing; used by every module of the engine.
package sm3_pkg;

	typedef struct packed {
		logic [31:0] msg_word;
		logic [2:0]  valid_bytes;
		logic        final_item;
	} msg_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic [2:0]  word_index;
		logic        last_word;
	} dig_t;

	// Chaining value, word 0 in the lowest slot
	typedef logic [7:0][31:0] chain_t;

	// Status of the compression unit
	typedef struct packed {
		logic rnd_act;
		logic done;
	} cmp_stat_t;

	localparam logic [31:0] T_LO   = 32'h79CC4519;
	localparam logic [31:0] T_HI   = 32'h7A879D8A;
	localparam logic [31:0] MARKER = 32'h80000000;

	localparam chain_t IV = {
		32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
		32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
	};

	function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] r);
		logic [63:0] d;
		d = {x, x} << r;
		return d[63:32];
	endfunction

	function automatic logic [31:0] perm0(input logic [31:0] x);
		return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
	endfunction

	function automatic logic [31:0] perm1(input logic [31:0] x);
		return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
	endfunction

endpackage

// ----- design/sm3_msg_sched.sv -----
// Message block store and expansion window: 16 words, shifted per push or round.
// Depends on sm3_pkg for the rotate and permutation functions.
module sm3_msg_sched (
	input  logic        clk,
	input  logic        push_en,
	input  logic [31:0] push_word,
	input  logic        shift_en,
	output logic [31:0] wj,
	output logic [31:0] wjx
);

	logic [31:0] win_q [16];
	logic [31:0] w_new;

	// W[j+16] from the current window
	assign w_new = sm3_pkg::perm1(win_q[0] ^ win_q[7] ^ sm3_pkg::rotl32(win_q[13], 5'd15))
		^ sm3_pkg::rotl32(win_q[3], 5'd7) ^ win_q[10];

	assign wj  = win_q[0];
	assign wjx = win_q[0] ^ win_q[4];

	always_ff @(posedge clk) begin
		if (push_en || shift_en) begin
			for (int i = 0; i < 15; i++) begin
				win_q[i] <= win_q[i + 1];
			end
			win_q[15] <= push_en ? push_word : w_new;
		end
	end

endmodule

// ----- design/sm3_compress.sv -----
// Compression unit: one SM3 round per cycle over 64 rounds, then a fold into the chain.
// Depends on sm3_pkg for types, constants and bit functions.
module sm3_compress (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                init_iv,
	input  logic [31:0]         wj,
	input  logic [31:0]         wjx,
	output sm3_pkg::chain_t     chain,
	output sm3_pkg::cmp_stat_t  stat
);

	sm3_pkg::chain_t chain_q;
	logic [31:0] a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;
	logic [5:0]  rnd_q;
	logic        run_q;
	logic        fold_q;

	logic        early;
	logic [31:0] t_rot, a12, ss1, ss2, ffv, ggv, tt1, tt2;

	assign early = (rnd_q[5:4] == 2'b00);

	always_comb begin
		t_rot = sm3_pkg::rotl32(early ? sm3_pkg::T_LO : sm3_pkg::T_HI, rnd_q[4:0]);
		a12   = sm3_pkg::rotl32(a_q, 5'd12);
		ss1   = sm3_pkg::rotl32(a12 + e_q + t_rot, 5'd7);
		ss2   = ss1 ^ a12;
		ffv   = early ? (a_q ^ b_q ^ c_q) : ((a_q & b_q) | (a_q & c_q) | (b_q & c_q));
		ggv   = early ? (e_q ^ f_q ^ g_q) : ((e_q & f_q) | (~e_q & g_q));
		tt1   = ffv + d_q + ss2 + wjx;
		tt2   = ggv + h_q + ss1 + wj;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q   <= 1'b0;
			fold_q  <= 1'b0;
			rnd_q   <= '0;
			chain_q <= sm3_pkg::IV;
		end else begin
			fold_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				rnd_q <= '0;
			end else if (run_q) begin
				rnd_q <= rnd_q + 6'd1;
				if (rnd_q == 6'd63) begin
					run_q  <= 1'b0;
					fold_q <= 1'b1;
				end
			end
			if (init_iv) begin
				chain_q <= sm3_pkg::IV;
			end else if (fold_q) begin
				chain_q <= chain_q ^ {h_q, g_q, f_q, e_q, d_q, c_q, b_q, a_q};
			end
		end
	end

	// working variables: load from the chain, then advance one round a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= chain_q[0];
			b_q <= chain_q[1];
			c_q <= chain_q[2];
			d_q <= chain_q[3];
			e_q <= chain_q[4];
			f_q <= chain_q[5];
			g_q <= chain_q[6];
			h_q <= chain_q[7];
		end else if (run_q) begin
			d_q <= c_q;
			c_q <= sm3_pkg::rotl32(b_q, 5'd9);
			b_q <= a_q;
			a_q <= tt1;
			h_q <= g_q;
			g_q <= sm3_pkg::rotl32(f_q, 5'd19);
			f_q <= e_q;
			e_q <= sm3_pkg::perm0(tt2);
		end
	end

	assign chain        = chain_q;
	assign stat.rnd_act = run_q;
	assign stat.done    = fold_q;

endmodule

// ----- design/sm3_hash_engine_core.sv -----
// SM3 hash engine top level: word intake, padding sequencer and digest output.
// Depends on sm3_pkg, sm3_msg_sched and sm3_compress.
//
// Usage:
//   msg channel (msg_valid/msg_ready/msg_data) takes the message as big-endian
//   32-bit words. A word without final_item counts as four bytes. The word with
//   final_item carries 0..4 leading bytes (values above four count as four).
//   dig channel (dig_valid/dig_ready/dig_data) returns the eight digest words,
//   word_index 0 first, last_word set on word 7.
// Timing:
//   The 16th word of a block starts the shared round unit; msg_ready stays
//   low through the rounds and the fold, so no new word is taken until the
//   block is folded. After the final word the sequencer pushes padding
//   words one per cycle and compresses one or two more blocks, then
//   presents the digest. Output words leave one per cycle while dig_ready
//   is high; a stalled receiver simply holds the digest in place and no new
//   word is taken.
// Reset:
//   arst_n clears the sequencer, the byte count and loads the SM3 initial
//   vector. After the last digest word the engine re-initializes the same way.
module sm3_hash_engine_core (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           msg_valid,
	output logic           msg_ready,
	input  sm3_pkg::msg_t  msg_data,
	output logic           dig_valid,
	input  logic           dig_ready,
	output sm3_pkg::dig_t  dig_data
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_COMP = 2'd1;
	localparam logic [1:0] ST_PAD  = 2'd2;
	localparam logic [1:0] ST_OUT  = 2'd3;

	logic [1:0]  state_q;
	logic [3:0]  cnt_q;         // words held in the current block
	logic [60:0] byte_total_q;
	logic        fin_q;         // final word seen, padding in progress
	logic        need_marker_q; // 0x80 marker word still to push
	logic        spill_q;       // marker took word 14: fill word 15 with zero, length goes next block
	logic        last_q;        // length words pushed, next fold ends message
	logic [2:0]  idx_q;

	logic               msg_acc;
	logic               dig_acc;
	logic               push_en;
	logic [31:0]        push_word;
	logic               start;
	logic               init_iv;
	logic [2:0]         nb;
	logic [63:0]        bit_len;
	logic [31:0]        fin_word;
	logic [31:0]        wj, wjx;
	sm3_pkg::chain_t    chain;
	sm3_pkg::cmp_stat_t stat;

	assign msg_ready = (state_q == ST_IDLE);
	assign dig_valid = (state_q == ST_OUT);
	assign msg_acc   = msg_valid && msg_ready;
	assign dig_acc   = dig_valid && dig_ready;

	// clip the byte count of the final word to four
	assign nb      = (msg_data.valid_bytes > 3'd4) ? 3'd4 : msg_data.valid_bytes;
	assign bit_len = {byte_total_q, 3'b000};

	// final word with fewer than four bytes: keep leading bytes, append marker
	always_comb begin
		case (nb[1:0])
			2'd1:    fin_word = {msg_data.msg_word[31:24], 24'h800000};
			2'd2:    fin_word = {msg_data.msg_word[31:16], 16'h8000};
			2'd3:    fin_word = {msg_data.msg_word[31:8], 8'h80};
			default: fin_word = sm3_pkg::MARKER;
		endcase
	end

	// select the word entering the block store this cycle
	always_comb begin
		push_en   = 1'b0;
		push_word = msg_data.msg_word;
		if (msg_acc) begin
			push_en = 1'b1;
			if (msg_data.final_item && nb != 3'd4) begin
				push_word = fin_word;
			end
		end else if (state_q == ST_PAD) begin
			push_en = 1'b1;
			if (need_marker_q) begin
				push_word = sm3_pkg::MARKER;
			end else if (cnt_q < 4'd14 || spill_q) begin
				push_word = '0;
			end else if (cnt_q == 4'd14) begin
				push_word = bit_len[63:32];
			end else begin
				push_word = bit_len[31:0];
			end
		end
	end

	// a push that fills the block starts the round unit
	assign start   = push_en && (cnt_q == 4'd15);
	assign init_iv = dig_acc && (idx_q == 3'd7);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			byte_total_q  <= '0;
			fin_q         <= 1'b0;
			need_marker_q <= 1'b0;
			spill_q       <= 1'b0;
			last_q        <= 1'b0;
			idx_q         <= '0;
		end else begin
			if (push_en) begin
				cnt_q <= cnt_q + 4'd1;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (msg_acc) begin
						if (msg_data.final_item) begin
							byte_total_q  <= byte_total_q + 61'(nb);
							fin_q         <= 1'b1;
							need_marker_q <= (nb == 3'd4);
							spill_q       <= (nb != 3'd4) && (cnt_q == 4'd14);
						end else begin
							byte_total_q <= byte_total_q + 61'd4;
						end
						if (start) begin
							state_q <= ST_COMP;
						end else if (msg_data.final_item) begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_PAD: begin
					need_marker_q <= 1'b0;
					// marker in word 14 leaves no room for the length here
					if (need_marker_q && cnt_q == 4'd14) begin
						spill_q <= 1'b1;
					end
					if (start) begin
						state_q <= ST_COMP;
						spill_q <= 1'b0;
						if (!need_marker_q && !spill_q) begin
							last_q <= 1'b1;
						end
					end
				end
				ST_COMP: begin
					// wait for the fold, then resume intake, padding or output
					if (stat.done) begin
						if (!fin_q) begin
							state_q <= ST_IDLE;
						end else if (last_q) begin
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_PAD;
						end
					end
				end
				ST_OUT: begin
					if (dig_acc) begin
						idx_q <= idx_q + 3'd1;
						if (idx_q == 3'd7) begin
							state_q      <= ST_IDLE;
							byte_total_q <= '0;
							fin_q        <= 1'b0;
							last_q       <= 1'b0;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	sm3_msg_sched u_sched (
		.clk       (clk),
		.push_en   (push_en),
		.push_word (push_word),
		.shift_en  (stat.rnd_act),
		.wj        (wj),
		.wjx       (wjx)
	);

	sm3_compress u_comp (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.init_iv (init_iv),
		.wj      (wj),
		.wjx     (wjx),
		.chain   (chain),
		.stat    (stat)
	);

	assign dig_data.digest_word = chain[idx_q];
	assign dig_data.word_index  = idx_q;
	assign dig_data.last_word   = (idx_q == 3'd7);

	// the round unit only finishes while the sequencer waits for it
	a_done_in_comp: assert property (@(posedge clk) disable iff (!arst_n)
		stat.done |-> state_q == ST_COMP)
		else $error("round unit finished outside compression wait");

	// the sequencer never leaves the wait before the fold
	a_comp_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMP && !stat.done) |=> state_q == ST_COMP)
		else $error("left compression wait early");

	// digest only shown on a block boundary with padding complete
	a_out_clean: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_OUT |-> (cnt_q == 4'd0 && !need_marker_q && last_q))
		else $error("digest presented with padding incomplete");

	// after the last digest word the message state is clear
	a_reinit: assert property (@(posedge clk) disable iff (!arst_n)
		(dig_acc && dig_data.last_word) |=> (byte_total_q == '0 && !fin_q
			&& state_q == ST_IDLE))
		else $error("engine not re-initialized after digest");

endmodule
